// File: src/ssi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set intersection - shared definitions
// Opcodes, queued command type, back-end state codes and default sizes.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 16;

  // Command queue between front and back end (power of two depth)
  localparam int QDEPTH = 2;
  localparam int QAW    = 1;
  localparam int QCW    = 2;

  // Opcodes on the input beat
  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_RUN    = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_RUN
  } cmd_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } back_state_e;

endpackage

// File: src/sorted_set_intersection_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set intersection - top level
// Loads two sets and emits their common distinct values in ascending order.
// ----------------------------------------------------------------------------
// A beat with op 0 or 1 appends value to set A or set B; once a set holds
// CAPACITY elements further loads are dropped and the overflow flag is kept
// until the next run. Loads are taken one per cycle while the command queue
// is not full. A beat with op 2 runs the intersection: every distinct value
// held in both sets comes out once, ascending, last set on the final result;
// an empty intersection gives one result with empty_res set and a zero value.
// The run then clears both sets and the overflow flag. Op 3 is accepted and
// dropped. A run makes one pass over all pairs of the two stores per result
// plus a final pass, each pass reading through the single read port of each
// store. Up to two beats are queued in the two-deep command queue while a
// run is in progress or a result waits to be taken.
// ----------------------------------------------------------------------------
module sorted_set_intersection_top #(
  parameter int CAPACITY = ssi_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input beats
  input  logic                              valid_i,
  output logic                              stall_o,
  input  logic [1:0]                        op_i,
  input  logic signed [ssi_pkg::DATA_W-1:0] value_i,
  // result beats
  output logic                              valid_o,
  input  logic                              stall_i,
  output logic signed [ssi_pkg::DATA_W-1:0] value_res_o,
  output logic                              last_o,
  output logic                              empty_res_o,
  output logic                              overflow_o
);

  logic          push, q_full, q_vld, pop;
  ssi_pkg::cmd_t push_cmd, q_cmd;

  // Decode and drop unused opcodes
  ssi_front u_front (
    .valid_i    (valid_i),
    .stall_o    (stall_o),
    .op_i       (op_i),
    .value_i    (value_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  // Hold commands while the back end is busy
  ssi_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .vld_o      (q_vld),
    .pop_cmd_o  (q_cmd)
  );

  // Execute loads and runs, drive the result register
  ssi_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_vld_i     (q_vld),
    .q_cmd_i     (q_cmd),
    .pop_o       (pop),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .value_res_o (value_res_o),
    .last_o      (last_o),
    .empty_res_o (empty_res_o),
    .overflow_o  (overflow_o)
  );

endmodule

// File: src/ssi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set intersection - front end
// Accepts input beats, decodes the opcode and drops the unused code.
// ----------------------------------------------------------------------------
module ssi_front (
  input  logic                             valid_i,
  output logic                             stall_o,
  input  logic [1:0]                       op_i,
  input  logic signed [ssi_pkg::DATA_W-1:0] value_i,
  input  logic                             q_full_i,
  output logic                             push_o,
  output ssi_pkg::cmd_t                    push_cmd_o
);

  logic legal;

  always_comb begin
    legal            = 1'b1;
    push_cmd_o.value = value_i;
    unique case (op_i)
      ssi_pkg::OP_LOAD_A: push_cmd_o.cmd = ssi_pkg::CMD_LOAD_A;
      ssi_pkg::OP_LOAD_B: push_cmd_o.cmd = ssi_pkg::CMD_LOAD_B;
      ssi_pkg::OP_RUN:    push_cmd_o.cmd = ssi_pkg::CMD_RUN;
      default: begin
        // unused code: accept and drop
        push_cmd_o.cmd = ssi_pkg::CMD_RUN;
        legal          = 1'b0;
      end
    endcase
  end

  assign stall_o = q_full_i;
  assign push_o  = valid_i && !q_full_i && legal;

endmodule

// File: src/ssi_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set intersection - command queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ssi_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ssi_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          vld_o,
  output ssi_pkg::cmd_t pop_cmd_o
);

  ssi_pkg::cmd_t                 entry_q [ssi_pkg::QDEPTH];
  logic [ssi_pkg::QAW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [ssi_pkg::QCW-1:0]       fill_q;
  logic                          do_push, do_pop;

  assign full_o    = (fill_q == ssi_pkg::QCW'(ssi_pkg::QDEPTH));
  assign vld_o     = (fill_q != '0);
  assign pop_cmd_o = entry_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && vld_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      fill_q <= fill_q + 1'b1;
      else if (do_pop && !do_push) fill_q <= fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

// File: src/ssi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set intersection - back end
// Holds both set stores, executes loads and runs, drives the result register.
// ----------------------------------------------------------------------------
module ssi_back #(
  parameter int CAPACITY = ssi_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_vld_i,
  input  ssi_pkg::cmd_t                     q_cmd_i,
  output logic                              pop_o,
  output logic                              valid_o,
  input  logic                              stall_i,
  output logic signed [ssi_pkg::DATA_W-1:0] value_res_o,
  output logic                              last_o,
  output logic                              empty_res_o,
  output logic                              overflow_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  ssi_pkg::back_state_e state_q, state_d;

  logic signed [ssi_pkg::DATA_W-1:0] mem_a [CAPACITY];
  logic signed [ssi_pkg::DATA_W-1:0] mem_b [CAPACITY];
  logic signed [ssi_pkg::DATA_W-1:0] rd_a_q, rd_b_q;
  logic                              cmp_vld_q;

  logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic          ovf_q, ovf_d;
  logic [AW-1:0] ia_q, ia_d, jb_q, jb_d;
  logic          best_found_q, best_found_d;
  logic signed [ssi_pkg::DATA_W-1:0] best_q, best_d;
  logic          have_last_q, have_last_d;
  logic signed [ssi_pkg::DATA_W-1:0] last_val_q, last_val_d;
  logic          pend_vld_q, pend_vld_d;
  logic signed [ssi_pkg::DATA_W-1:0] pend_q, pend_d;

  logic wr_a_en, wr_b_en, hit, emit_need, out_free, load_out;

  logic                              out_vld_q;
  logic signed [ssi_pkg::DATA_W-1:0] out_val_q;
  logic                              out_last_q, out_empty_q, out_ovf_q;

  // Candidate: common value above the last one found and below the best so far
  assign hit = cmp_vld_q && (rd_a_q == rd_b_q)
            && (!have_last_q || (rd_a_q > last_val_q))
            && (!best_found_q || (rd_a_q < best_q));

  assign out_free  = !out_vld_q || !stall_i;
  assign emit_need = !best_found_q || pend_vld_q;

  always_comb begin
    state_d      = state_q;
    cnt_a_d      = cnt_a_q;
    cnt_b_d      = cnt_b_q;
    ovf_d        = ovf_q;
    ia_d         = ia_q;
    jb_d         = jb_q;
    best_found_d = best_found_q || hit;
    best_d       = hit ? rd_a_q : best_q;
    have_last_d  = have_last_q;
    last_val_d   = last_val_q;
    pend_vld_d   = pend_vld_q;
    pend_d       = pend_q;
    wr_a_en      = 1'b0;
    wr_b_en      = 1'b0;
    pop_o        = 1'b0;
    load_out     = 1'b0;
    unique case (state_q)
      ssi_pkg::ST_IDLE: begin
        if (q_vld_i) begin
          pop_o = 1'b1;
          unique case (q_cmd_i.cmd)
            ssi_pkg::CMD_LOAD_A: begin
              if (cnt_a_q < CW'(CAPACITY)) begin
                wr_a_en = 1'b1;
                cnt_a_d = cnt_a_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            ssi_pkg::CMD_LOAD_B: begin
              if (cnt_b_q < CW'(CAPACITY)) begin
                wr_b_en = 1'b1;
                cnt_b_d = cnt_b_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            ssi_pkg::CMD_RUN: begin
              have_last_d  = 1'b0;
              pend_vld_d   = 1'b0;
              best_found_d = 1'b0;
              ia_d         = '0;
              jb_d         = '0;
              state_d      = (cnt_a_q == '0 || cnt_b_q == '0) ? ssi_pkg::ST_FINISH
                                                              : ssi_pkg::ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ssi_pkg::ST_SCAN: begin
        // walk every (A, B) pair, B inner
        if (CW'(jb_q) == cnt_b_q - 1'b1) begin
          jb_d = '0;
          if (CW'(ia_q) == cnt_a_q - 1'b1) begin
            state_d = ssi_pkg::ST_DRAIN;
          end else begin
            ia_d = ia_q + 1'b1;
          end
        end else begin
          jb_d = jb_q + 1'b1;
        end
      end
      ssi_pkg::ST_DRAIN: begin
        state_d = ssi_pkg::ST_FINISH;
      end
      ssi_pkg::ST_FINISH: begin
        if (!emit_need || out_free) begin
          load_out = emit_need;
          if (best_found_q) begin
            // hold the new minimum back until we know whether it is the last
            pend_d       = best_q;
            pend_vld_d   = 1'b1;
            have_last_d  = 1'b1;
            last_val_d   = best_q;
            best_found_d = 1'b0;
            ia_d         = '0;
            jb_d         = '0;
            state_d      = ssi_pkg::ST_SCAN;
          end else begin
            cnt_a_d = '0;
            cnt_b_d = '0;
            ovf_d   = 1'b0;
            state_d = ssi_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = ssi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ssi_pkg::ST_IDLE;
      cnt_a_q      <= '0;
      cnt_b_q      <= '0;
      ovf_q        <= 1'b0;
      ia_q         <= '0;
      jb_q         <= '0;
      best_found_q <= 1'b0;
      have_last_q  <= 1'b0;
      pend_vld_q   <= 1'b0;
      cmp_vld_q    <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_a_q      <= cnt_a_d;
      cnt_b_q      <= cnt_b_d;
      ovf_q        <= ovf_d;
      ia_q         <= ia_d;
      jb_q         <= jb_d;
      best_found_q <= best_found_d;
      have_last_q  <= have_last_d;
      pend_vld_q   <= pend_vld_d;
      cmp_vld_q    <= (state_q == ssi_pkg::ST_SCAN);
      if (load_out)      out_vld_q <= 1'b1;
      else if (!stall_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    last_val_q <= last_val_d;
    pend_q     <= pend_d;
    if (load_out) begin
      out_val_q   <= pend_vld_q ? pend_q : '0;
      out_last_q  <= !best_found_q;
      out_empty_q <= !best_found_q && !pend_vld_q;
      out_ovf_q   <= ovf_q;
    end
  end

  // Set stores: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (wr_a_en) mem_a[cnt_a_q[AW-1:0]] <= q_cmd_i.value;
    if (wr_b_en) mem_b[cnt_b_q[AW-1:0]] <= q_cmd_i.value;
    rd_a_q <= mem_a[ia_q];
    rd_b_q <= mem_b[jb_q];
  end

  assign valid_o     = out_vld_q;
  assign value_res_o = out_val_q;
  assign last_o      = out_last_q;
  assign empty_res_o = out_empty_q;
  assign overflow_o  = out_ovf_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= CW'(CAPACITY)) && (cnt_b_q <= CW'(CAPACITY)))
    else $error("set count beyond capacity");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ssi_pkg::ST_SCAN) |-> (cnt_a_q != '0) && (cnt_b_q != '0))
    else $error("scan started on an empty set");

  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_empty_q) |-> (out_last_q && (out_val_q == '0)))
    else $error("empty result malformed");

  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ssi_pkg::ST_FINISH && !best_found_q && out_free)
    |=> (state_q == ssi_pkg::ST_IDLE) && (cnt_a_q == '0) && (cnt_b_q == '0) && !ovf_q)
    else $error("run did not clear the sets");
`endif

endmodule
